// File: design/dq_pkg.sv
package dq_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_BACK  = 3'd5;
    localparam logic [2:0] OP_READ_IDX   = 3'd6;
    localparam logic [2:0] OP_WRITE_IDX  = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [5:0]         index;
    } t_in;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic [6:0]         count;
    } t_out;

    // per-cell steering: load the new word, take from the lower or the upper neighbour, or drive the read bus
    typedef struct packed {
        logic load;
        logic from_low;
        logic from_high;
        logic rd_sel;
    } t_cell_ctl;

endpackage

// File: design/dq_cell.sv
module dq_cell #(
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  dq_pkg::t_cell_ctl            i_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_new,
    input  logic signed [DATA_WIDTH-1:0] i_low,
    input  logic signed [DATA_WIDTH-1:0] i_high,
    output logic signed [DATA_WIDTH-1:0] o_word,
    output logic signed [DATA_WIDTH-1:0] o_rd
);
    import dq_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_word;
    logic signed [DATA_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.load) begin
            n_word = i_new;
        end else if (i_ctl.from_low) begin
            n_word = i_low;
        end else if (i_ctl.from_high) begin
            n_word = i_high;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    // gate onto the shared read bus
    assign o_rd   = i_ctl.rd_sel ? r_word : '0;

endmodule

// File: design/double_ended_queue.sv
// Channel   Handshake        Payload            Direction
// command   start / busy     i_item (t_in)      in
// result    o_done strobe    o_result (t_out)   out
//
// One operation per clock while busy is low: an item accepted at one edge has its result on
// o_result, with o_done high, for the following cycle. The row of cells
// shifts or loads in that same edge, so a new item is taken every cycle busy is low.
// Reset is synchronous; busy is held high in reset and is cleared by a register once reset is released.
// The receiver cannot stall: every result is shown once and then dropped.
module double_ended_queue #(
    parameter int CAPACITY   = dq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  dq_pkg::t_in   i_item,
    output logic          o_done,
    output dq_pkg::t_out  o_result
);
    import dq_pkg::*;

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > 6) ? FW : 6;

    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic          r_busy;
    logic          r_done;
    t_out          r_out;
    t_out          n_out;
    logic [1:0]    n_status;

    logic                         acc;
    logic                         full;
    logic                         empty;
    logic                         idx_ok;
    logic [CW-1:0]                idx_w;
    logic [CW-1:0]                back_pos;
    logic [CW-1:0]                rd_pos;
    logic [CW-1:0]                wr_pos;
    logic                         rd_en;
    logic                         wr_en;
    logic                         shift_up;
    logic                         shift_down;
    logic signed [DATA_WIDTH-1:0] new_word;
    logic signed [DATA_WIDTH-1:0] rd_word;

    t_cell_ctl                    ctl   [CAPACITY];
    logic signed [DATA_WIDTH-1:0] words [CAPACITY];
    logic signed [DATA_WIDTH-1:0] rd_bus[CAPACITY];

    assign acc      = start && !busy;
    assign full     = (r_fill == FW'(CAPACITY));
    assign empty    = (r_fill == '0);
    assign idx_w    = CW'(i_item.index);
    assign idx_ok   = idx_w < CW'(r_fill);
    assign back_pos = CW'(r_fill) - CW'(1);
    assign new_word = DATA_WIDTH'(i_item.value);

    always_comb begin
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        shift_up   = 1'b0;
        shift_down = 1'b0;
        rd_pos     = '0;
        wr_pos     = '0;
        n_fill     = r_fill;
        n_status   = ST_OK;
        case (i_item.op)
            OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    shift_up = acc;
                    n_fill   = r_fill + FW'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en  = acc;
                    wr_pos = CW'(r_fill);
                    n_fill = r_fill + FW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en      = 1'b1;
                    shift_down = acc;
                    n_fill     = r_fill - FW'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en  = 1'b1;
                    rd_pos = back_pos;
                    n_fill = r_fill - FW'(1);
                end
            end
            OP_PEEK_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en = 1'b1;
                end
            end
            OP_PEEK_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en  = 1'b1;
                    rd_pos = back_pos;
                end
            end
            OP_READ_IDX: begin
                if (!idx_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    rd_en  = 1'b1;
                    rd_pos = idx_w;
                end
            end
            OP_WRITE_IDX: begin
                if (!idx_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    wr_en  = acc;
                    wr_pos = idx_w;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // front element sits in cell 0, back element in cell fill-1
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] low_in;
        logic signed [DATA_WIDTH-1:0] high_in;

        if (g == 0) begin : g_first
            assign low_in = new_word;
        end else begin : g_mid_low
            assign low_in = words[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign high_in = words[g];
        end else begin : g_mid_high
            assign high_in = words[g+1];
        end

        assign ctl[g].load      = wr_en && (wr_pos == CW'(g));
        assign ctl[g].from_low  = shift_up;
        assign ctl[g].from_high = shift_down;
        assign ctl[g].rd_sel    = rd_en && (rd_pos == CW'(g));

        dq_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl[g]),
            .i_new  (new_word),
            .i_low  (low_in),
            .i_high (high_in),
            .o_word (words[g]),
            .o_rd   (rd_bus[g])
        );
    end

    always_comb begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_word = rd_word | rd_bus[i];
        end
    end

    assign n_out = '{data: 32'(rd_word), status: n_status, count: 7'(n_fill)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_done <= acc;
            if (acc) begin
                r_fill <= n_fill;
            end
        end
    end

    // hold the last result; o_done marks the one valid beat
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out <= n_out;
        end
    end

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

// File: design/dq_checker.sv
module dq_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         start,
    input logic         busy,
    input dq_pkg::t_in  i_item,
    input logic         o_done,
    input dq_pkg::t_out o_result
);
    import dq_pkg::*;

    // every accepted beat yields exactly one result in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted beat gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without an accepted beat");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |-> (o_result.data == '0))
        else $error("failed operation returned data");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_EMPTY) |-> (o_result.count == '0))
        else $error("empty status with nonzero count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done)) |->
            ((o_result.count == $past(o_result.count)) ||
             (o_result.count == $past(o_result.count) + 7'd1) ||
             (o_result.count + 7'd1 == $past(o_result.count))))
        else $error("count moved by more than one");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import dq_pkg::*;

    localparam int DEPTH = CAPACITY_DEF;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_in  i_item  = '0;
    logic o_done;
    t_out o_result;

    double_ended_queue uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // shadow copy of the deque contents and pointers
    logic signed [31:0] dq_store [DEPTH];
    logic [5:0]         dq_head;
    logic [5:0]         dq_tail;
    int                 dq_fill;

    t_out        pending_results[$];
    int unsigned failures = 0;
    bit          idle_en  = 1'b1;

    function automatic t_out deque_apply(input t_in it);
        t_out r;
        logic [5:0] pos;
        r.data   = '0;
        r.status = ST_OK;
        case (it.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (dq_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // an empty deque takes the word in place
                    if (dq_fill != 0) begin
                        if (it.op == OP_PUSH_FRONT) dq_head = dq_head - 6'd1;
                        else dq_tail = dq_tail + 6'd1;
                    end
                    dq_store[(it.op == OP_PUSH_FRONT) ? dq_head : dq_tail] = it.value;
                    dq_fill++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (dq_fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (it.op == OP_POP_FRONT) begin
                    r.data = dq_store[dq_head];
                    if (dq_fill > 1) dq_head = dq_head + 6'd1;
                    dq_fill--;
                end else begin
                    r.data = dq_store[dq_tail];
                    if (dq_fill > 1) dq_tail = dq_tail - 6'd1;
                    dq_fill--;
                end
            end
            OP_PEEK_FRONT, OP_PEEK_BACK: begin
                if (dq_fill == 0) r.status = ST_EMPTY;
                else r.data = dq_store[(it.op == OP_PEEK_FRONT) ? dq_head : dq_tail];
            end
            default: begin
                if (int'(it.index) >= dq_fill) begin
                    r.status = ST_RANGE;
                end else begin
                    pos = dq_head + it.index;
                    if (it.op == OP_READ_IDX) r.data = dq_store[pos];
                    else dq_store[pos] = it.value;
                end
            end
        endcase
        r.count = dq_fill[6:0];
        return r;
    endfunction

    // entered just after a falling edge, returns just after one
    task automatic send_op(input t_in it);
        t_in noise;
        if (idle_en && $urandom_range(99) < 7) begin
            noise = $bits(t_in)'({$urandom, $urandom});
            start  <= 1'b0;
            i_item <= noise;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.insert(pending_results.size(), deque_apply(it));
        @(negedge i_clk);
    endtask

    task automatic do_op(input logic [2:0] op, input logic [31:0] value,
                         input logic [5:0] index);
        t_in it;
        it.op    = op;
        it.value = value;
        it.index = index;
        send_op(it);
    endtask

    // push_w and pop_w are percentages; the rest goes to peeks and indexed access
    task automatic random_ops(input int n, input int push_w, input int pop_w);
        t_in it;
        int  r;
        repeat (n) begin
            r = $urandom_range(99);
            it.value = $urandom;
            if ($urandom_range(9) < 8 && dq_fill > 0)
                it.index = 6'($urandom_range(dq_fill - 1));
            else
                it.index = 6'($urandom_range(63));
            if (r < push_w)
                it.op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else if (r < push_w + pop_w)
                it.op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
            else
                case ($urandom_range(3))
                    0:       it.op = OP_PEEK_FRONT;
                    1:       it.op = OP_PEEK_BACK;
                    2:       it.op = OP_READ_IDX;
                    default: it.op = OP_WRITE_IDX;
                endcase
            send_op(it);
        end
    endtask

    task automatic test_empty_queue;
        do_op(OP_POP_FRONT,  32'h0, 6'd0);
        do_op(OP_POP_BACK,   32'h0, 6'd0);
        do_op(OP_PEEK_FRONT, 32'h0, 6'd0);
        do_op(OP_PEEK_BACK,  32'h0, 6'd0);
        do_op(OP_READ_IDX,   32'h0, 6'd0);
        do_op(OP_WRITE_IDX,  32'h1234_5678, 6'd0);
    endtask

    task automatic test_single_element;
        do_op(OP_PUSH_FRONT, 32'h7FFF_FFFF, 6'd0);
        do_op(OP_PEEK_FRONT, 32'h0, 6'd0);
        do_op(OP_PEEK_BACK,  32'h0, 6'd0);
        do_op(OP_READ_IDX,   32'h0, 6'd0);
        do_op(OP_READ_IDX,   32'h0, 6'd1);
        do_op(OP_POP_BACK,   32'h0, 6'd0);
        do_op(OP_PUSH_BACK,  32'h8000_0000, 6'd0);
        do_op(OP_POP_FRONT,  32'h0, 6'd0);
    endtask

    task automatic test_extremes;
        do_op(OP_PUSH_BACK,  32'hFFFF_FFFF, 6'd0);
        do_op(OP_PUSH_FRONT, 32'h0000_0000, 6'd0);
        do_op(OP_PUSH_BACK,  32'h8000_0000, 6'd0);
        do_op(OP_PUSH_FRONT, 32'h7FFF_FFFF, 6'd0);
        do_op(OP_WRITE_IDX,  32'h5A5A_A5A5, 6'd3);
        do_op(OP_WRITE_IDX,  32'hDEAD_BEEF, 6'd63);
        do_op(OP_READ_IDX,   32'h0, 6'd3);
        do_op(OP_READ_IDX,   32'h0, 6'd63);
        do_op(OP_POP_FRONT,  32'h0, 6'd0);
        do_op(OP_POP_BACK,   32'h0, 6'd0);
        do_op(OP_POP_FRONT,  32'h0, 6'd0);
        do_op(OP_POP_BACK,   32'h0, 6'd0);
    endtask

    // mostly pushes: run into the full limit and wrap both pointers
    task automatic test_fill_to_capacity;
        random_ops(300, 60, 15);
    endtask

    task automatic test_drain_to_empty;
        random_ops(300, 15, 60);
    endtask

    task automatic test_back_to_back;
        idle_en = 1'b0;
        random_ops(400, 35, 35);
        idle_en = 1'b1;
    endtask

    task automatic test_pause_until_drained;
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        random_ops(200, 40, 35);
    endtask

    task automatic test_random_sweep;
        repeat (2) begin
            random_ops(110, 65, 15);
            random_ops(110, 15, 65);
        end
    endtask

    always @(posedge i_clk) begin : check_result
        t_out want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("tb: unexpected result data=%h status=%0d count=%0d",
                             o_result.data, o_result.status, o_result.count);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_result.data !== want.data || o_result.status !== want.status ||
                    o_result.count !== want.count) begin
                    failures++;
                    if (failures <= 10)
                        $display("tb: mismatch exp data=%h status=%0d count=%0d,",
                                 want.data, want.status, want.count,
                                 " got data=%h status=%0d count=%0d",
                                 o_result.data, o_result.status, o_result.count);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) dq_store[i] = '0;
        dq_head = 6'(DEPTH / 2);
        dq_tail = 6'(DEPTH / 2);
        dq_fill = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_queue;
        test_single_element;
        test_extremes;
        test_fill_to_capacity;
        test_drain_to_empty;
        test_back_to_back;
        test_pause_until_drained;
        test_random_sweep;

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (failures == 0 && pending_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// File: files.f
design/dq_pkg.sv
design/dq_cell.sv
design/double_ended_queue.sv
design/dq_checker.sv
verif/tb.sv
